// File: rtl/pbfb_pkg.sv
// ----------------------------------------------------------------------------
// pbfb_pkg: shared types and constants of the biquad formant bank
// Field widths, operation and coefficient codes, and the layout of one
// history row as it is kept in the history memory.
// ----------------------------------------------------------------------------
`default_nettype none

package pbfb_pkg;

  localparam int unsigned SAMPLE_W = 24;
  localparam int unsigned COEF_W   = 32;
  localparam int unsigned YOUT_W   = 32;
  localparam int unsigned TAPS     = 5;

  // Operation codes of an input word.
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_COEF   = 1'b1;

  // Coefficient select codes, in the order they sit in the store.
  localparam logic [2:0] C_B0 = 3'd0;
  localparam logic [2:0] C_B1 = 3'd1;
  localparam logic [2:0] C_B2 = 3'd2;
  localparam logic [2:0] C_A1 = 3'd3;
  localparam logic [2:0] C_A2 = 3'd4;

  // Output saturation bounds in Q1.23.
  localparam logic [SAMPLE_W-1:0] SAT_POS = 24'h7FFFFF;
  localparam logic [SAMPLE_W-1:0] SAT_NEG = 24'h800000;

  // One filter slot's history: two past inputs and two past outputs.
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] x1;
    logic signed [SAMPLE_W-1:0] x2;
    logic signed [YOUT_W-1:0]   y1;
    logic signed [YOUT_W-1:0]   y2;
  } hist_row_t;

endpackage

`default_nettype wire

// File: rtl/parallel_biquad_formant_bank.sv
// ----------------------------------------------------------------------------
// parallel_biquad_formant_bank: parallel biquad bank with shared MAC
// Runs one audio word through BANDS direct-form-1 biquads that share a
// single 32x32 multiplier, then averages the band outputs and saturates.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake                  Payload
//  item     in         item_valid / item_stall    operation, channel, sample_in,
//                                                 band, coeff_select, coeff_value
//  result   out        result_valid / result_stall sample_out, channel_out
//
// A coefficient write produces no result. An audio word goes through the
// bands in turn: each band fetches its history, runs its five taps through
// the shared multiplier, drains the product and writes its history back;
// then the magnitude of the band sum is formed, multiplied by a fixed
// reciprocal of 2*BANDS on the same multiplier, and loaded into the result
// register. item_stall is high from acceptance until that load, and longer
// while a finished word waits behind a held result.
// Reset is synchronous; it clears the sequencer and the valid bits of both
// memories, so every coefficient and every history entry reads as zero until
// written. A held result only delays the write of the next result; the block
// keeps accepting and working on the next word meanwhile.
//
`default_nettype none

module parallel_biquad_formant_bank
  import pbfb_pkg::*;
#(
  parameter int unsigned BANDS    = 4,
  parameter int unsigned CHANNELS = 2
) (
  input  wire logic                       clk,
  input  wire logic                       rst,

  input  wire logic                       item_valid,
  output logic                            item_stall,
  input  wire logic                       operation,
  input  wire logic                       channel,
  input  wire logic signed [SAMPLE_W-1:0] sample_in,
  input  wire logic [1:0]                 band,
  input  wire logic [2:0]                 coeff_select,
  input  wire logic signed [COEF_W-1:0]   coeff_value,

  output logic                            result_valid,
  input  wire logic                       result_stall,
  output logic signed [SAMPLE_W-1:0]      sample_out,
  output logic                            channel_out
);

  // Store sizes and the widths that follow from them.
  localparam int unsigned NCOEF = TAPS * BANDS;
  localparam int unsigned NSLOT = CHANNELS * BANDS;
  localparam int unsigned CA_W  = $clog2(NCOEF);
  localparam int unsigned SA_W  = (NSLOT > 1) ? $clog2(NSLOT) : 1;
  localparam int unsigned BC_W  = (BANDS > 1) ? $clog2(BANDS) : 1;
  localparam int unsigned WA_W  = CA_W + 3;
  // Sum of BANDS saturated 32-bit band outputs fits in TOT_W signed bits.
  localparam int unsigned TOT_W = YOUT_W + $clog2(BANDS);
  localparam int unsigned DIV   = 2 * BANDS;
  localparam int unsigned DIV_L = $clog2(DIV);
  // Magnitudes of 2^QN and above saturate in either direction; below that
  // the rounded-up reciprocal gives the exact floor quotient.
  localparam int unsigned QN    = SAMPLE_W + DIV_L;
  localparam int unsigned QS    = QN + DIV_L;
  localparam logic [COEF_W-1:0] RECIP =
    COEF_W'(((64'd1 << QS) + 64'(DIV) - 64'd1) / 64'(DIV));

  // Sequencer states.
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LOAD  = 3'd1;
  localparam logic [2:0] S_MAC   = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_BEND  = 3'd4;
  localparam logic [2:0] S_PREP  = 3'd5;
  localparam logic [2:0] S_DIV   = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  logic [2:0] state;

  // Handshake decode.
  logic item_acc;
  logic result_acc;
  logic out_load;
  logic coef_ok;
  logic chan_ok;
  logic coef_we;
  logic start;
  logic [WA_W-1:0] coef_wsum;
  logic [CA_W-1:0] coef_waddr;

  assign item_stall = (state != S_IDLE);
  assign item_acc   = item_valid && !item_stall;
  assign result_acc = result_valid && !result_stall;
  assign out_load   = (state == S_OUT) && (!result_valid || !result_stall);

  // Writes to a band or select outside the store are dropped, as are words
  // for a channel the bank does not have.
  assign coef_ok   = (int'(band) < int'(BANDS)) && (coeff_select <= C_A2);
  assign chan_ok   = (CHANNELS > 1) || (channel == 1'b0);
  assign coef_we   = item_acc && (operation == OP_COEF) && coef_ok;
  assign start     = item_acc && (operation == OP_SAMPLE) && chan_ok;
  assign coef_wsum = WA_W'(band) * WA_W'(TAPS) + WA_W'(coeff_select);
  assign coef_waddr = coef_wsum[CA_W-1:0];

  // Walk counters. Coefficients are stored band by band, tap by tap, so one
  // running address covers the whole pass over the bank.
  logic [2:0]      tap;
  logic [BC_W-1:0] bcnt;
  logic [CA_W-1:0] cidx;
  logic [SA_W-1:0] hidx;
  logic [CA_W-1:0] cidx_inc;
  logic [SA_W-1:0] hidx_inc;
  logic            last_band;

  assign cidx_inc  = (cidx == CA_W'(NCOEF - 1)) ? '0 : cidx + 1'b1;
  assign hidx_inc  = (hidx == SA_W'(NSLOT - 1)) ? '0 : hidx + 1'b1;
  assign last_band = (bcnt == BC_W'(BANDS - 1));

  // Coefficient memory with one valid bit per entry; an entry never written
  // since reset reads as zero.
  logic signed [COEF_W-1:0] coef_mem [NCOEF];
  logic [NCOEF-1:0]         coef_vld;
  logic signed [COEF_W-1:0] coef_rd;
  logic                     coef_rd_vld;
  logic signed [COEF_W-1:0] coef_eff;

  always_ff @(posedge clk) begin
    if (coef_we) begin
      coef_mem[coef_waddr] <= coeff_value;
    end
    coef_rd <= coef_mem[cidx];
  end

  assign coef_eff = coef_rd_vld ? coef_rd : '0;

  // History memory, one row per channel and band.
  hist_row_t       hist_mem [NSLOT];
  logic [NSLOT-1:0] hist_vld;
  hist_row_t       hist_rd;
  logic            hist_rd_vld;
  hist_row_t       hist_eff;
  hist_row_t       hist_wr;
  logic            hist_we;

  assign hist_we = (state == S_BEND);

  always_ff @(posedge clk) begin
    if (hist_we) begin
      hist_mem[hidx] <= hist_wr;
    end
    hist_rd <= hist_mem[hidx];
  end

  assign hist_eff = hist_rd_vld ? hist_rd : '0;

  // Shared multiplier. The tap code picks the history operand; the product
  // is registered before it reaches the accumulator. In the divide step the
  // same multiplier takes the magnitude of the band sum and the reciprocal.
  logic signed [SAMPLE_W-1:0]      x;
  logic                            ch;
  logic [TOT_W-1:0]                mag;
  logic signed [COEF_W-1:0]        mul_a;
  logic signed [COEF_W-1:0]        mul_b;
  logic signed [2*COEF_W-1:0]      prod;
  logic [2:0]                      prod_tap;
  logic                            prod_vld;
  logic signed [2*COEF_W-1:0]      acc;
  logic signed [2*COEF_W-1:0]      acc_next;

  always_comb begin
    mul_a = coef_eff;
    unique case (tap)
      C_B0:    mul_b = COEF_W'(x);
      C_B1:    mul_b = COEF_W'(hist_eff.x1);
      C_B2:    mul_b = COEF_W'(hist_eff.x2);
      C_A1:    mul_b = hist_eff.y1;
      C_A2:    mul_b = hist_eff.y2;
      default: mul_b = '0;
    endcase
    if (state == S_DIV) begin
      mul_a = COEF_W'(mag[QN-1:0]);
      mul_b = RECIP;
    end
  end

  // Input taps are doubled; feedback taps are halved with floor and
  // subtracted, so every term lands at scale 2^52.
  always_comb begin
    if (!prod_vld) begin
      acc_next = acc;
    end else if (prod_tap >= C_A1) begin
      acc_next = acc - (prod >>> 1);
    end else begin
      acc_next = acc + (prod <<< 1);
    end
  end

  // Band output: round half up to Q7.25, then saturate to 32 bits.
  logic signed [2*COEF_W-1:0] rnd;
  logic                       y_fit;
  logic signed [YOUT_W-1:0]   y_val;
  logic signed [TOT_W-1:0]    total;

  assign rnd   = acc + 64'sd67108864;
  assign y_fit = (rnd[63:58] == {6{rnd[63]}});
  assign y_val = y_fit ? rnd[58:27]
                       : (rnd[63] ? 32'sh80000000 : 32'sh7FFFFFFF);

  always_comb begin
    hist_wr.x1 = x;
    hist_wr.x2 = hist_eff.x1;
    hist_wr.y1 = y_val;
    hist_wr.y2 = hist_eff.y1;
  end

  // Mean with ties away from zero: (|total| + BANDS) / (2*BANDS) as one
  // multiply by a rounded-up reciprocal and a shift, then restore the sign.
  logic                 neg;
  logic [TOT_W-1:0]     abs_total;
  logic                 mag_big;
  logic [TOT_W-1:0]     quo;
  logic signed [SAMPLE_W-1:0] res_val;

  assign abs_total = total[TOT_W-1] ? (~total + 1'b1) : total;
  assign mag_big   = |mag[TOT_W-1:QN];
  assign quo       = TOT_W'(prod >>> QS);

  always_comb begin
    if (neg) begin
      res_val = (mag_big || (quo > TOT_W'(SAT_NEG))) ? SAT_NEG
                                                      : (~quo[SAMPLE_W-1:0] + 1'b1);
    end else begin
      res_val = (mag_big || (quo > TOT_W'(SAT_POS))) ? SAT_POS : quo[SAMPLE_W-1:0];
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      tap          <= C_B0;
      bcnt         <= '0;
      cidx         <= '0;
      hidx         <= '0;
      prod_vld     <= 1'b0;
      result_valid <= 1'b0;
      coef_vld     <= '0;
      hist_vld     <= '0;
      coef_rd_vld  <= 1'b0;
      hist_rd_vld  <= 1'b0;
    end else begin
      coef_rd_vld <= coef_vld[cidx];
      hist_rd_vld <= hist_vld[hidx];
      prod_vld    <= (state == S_MAC);
      if (coef_we) begin
        coef_vld[coef_waddr] <= 1'b1;
      end
      if (hist_we) begin
        hist_vld[hidx] <= 1'b1;
      end
      if (out_load) begin
        result_valid <= 1'b1;
      end else if (result_acc) begin
        result_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_LOAD;
            bcnt  <= '0;
            cidx  <= '0;
            hidx  <= channel ? SA_W'(BANDS) : '0;
          end
        end
        S_LOAD: begin
          state <= S_MAC;
          tap   <= C_B0;
          cidx  <= cidx_inc;
        end
        S_MAC: begin
          if (tap == C_A2) begin
            state <= S_DRAIN;
          end else begin
            tap  <= tap + 1'b1;
            cidx <= cidx_inc;
          end
        end
        S_DRAIN: begin
          state <= S_BEND;
        end
        S_BEND: begin
          hidx <= hidx_inc;
          bcnt <= bcnt + 1'b1;
          state <= last_band ? S_PREP : S_LOAD;
        end
        S_PREP: begin
          state <= S_DIV;
        end
        S_DIV: begin
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (start) begin
      x  <= sample_in;
      ch <= channel;
    end
    if ((state == S_MAC) || (state == S_DIV)) begin
      prod <= mul_a * mul_b;
    end
    if (state == S_MAC) begin
      prod_tap <= tap;
    end
    if (state == S_LOAD) begin
      acc <= '0;
    end else begin
      acc <= acc_next;
    end
    if (start) begin
      total <= '0;
    end else if (state == S_BEND) begin
      total <= total + TOT_W'(y_val);
    end
    if (state == S_PREP) begin
      neg <= total[TOT_W-1];
      mag <= abs_total + TOT_W'(BANDS);
    end
    if (out_load) begin
      sample_out  <= res_val;
      channel_out <= ch;
    end
  end

endmodule

`default_nettype wire

// File: sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for parallel_biquad_formant_bank
// Drives coefficient writes and audio words through the valid/stall input
// channel. A scoreboard keeps its own copy of the coefficients and of every
// band's history, predicts each averaged output word, and compares it field
// by field with what the result channel delivers. Both sides idle at random.
// ----------------------------------------------------------------------------

module testbench
  import pbfb_pkg::*;
;

  localparam int BANDS    = 4;
  localparam int CHANNELS = 2;

  localparam int CLK_PERIOD = 8;
  localparam int RESET_CYCLES = 9;

  // Stimulus volume: counted words are audio words and coefficient writes
  // that land in the store. The final stretch runs with no idling at all.
  localparam int ITEM_TARGET = 1500;
  localparam int QUIET_ITEMS = 150;

  // The quiet stretch at the end outlasts the processing of one audio word,
  // so it is enough to catch a stray extra result.
  localparam int DRAIN_CYCLES = 100;
  localparam int LONG_HOLD_CYCLES = 600;
  localparam int unsigned LIMIT_CYCLES = 1_000_000;

  // Q4.28 unity and the bounds used to build stable random sections.
  localparam int COEF_ONE = 1 << (COEF_W - 4);
  localparam int A2_LIMIT = COEF_ONE - COEF_ONE / 16;
  localparam int STABILITY_MARGIN = COEF_ONE / 32;
  localparam int SMALL_SAMPLE = 1 << 20;

  // The select field is three bits wide; codes from TAPS up are not taps.
  localparam int SEL_LAST = 7;

  localparam logic signed [COEF_W-1:0] COEF_MAX = {1'b0, {(COEF_W - 1){1'b1}}};
  localparam logic signed [COEF_W-1:0] COEF_MIN = {1'b1, {(COEF_W - 1){1'b0}}};

  localparam longint Y_MAX = (longint'(1) << (YOUT_W - 1)) - 1;
  localparam longint Y_MIN = -(longint'(1) << (YOUT_W - 1));
  localparam longint OUT_MAX = (longint'(1) << (SAMPLE_W - 1)) - 1;
  localparam longint OUT_MIN = -(longint'(1) << (SAMPLE_W - 1));

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       channel;
  } bank_output_t;

  // --------------------------------------------------------------------------
  // Scoreboard. note_word applies an accepted input word to the local copy of
  // the bank; an audio word queues the averaged output it must produce.
  // check_result pops the oldest expected word and compares both fields.
  // --------------------------------------------------------------------------
  class bank_scoreboard;
    logic signed [COEF_W-1:0]   coef [BANDS][TAPS];
    logic signed [SAMPLE_W-1:0] x_past1 [CHANNELS][BANDS];
    logic signed [SAMPLE_W-1:0] x_past2 [CHANNELS][BANDS];
    logic signed [YOUT_W-1:0]   y_past1 [CHANNELS][BANDS];
    logic signed [YOUT_W-1:0]   y_past2 [CHANNELS][BANDS];
    bank_output_t               expected_outputs [$];
    int                         errors;

    function new();
      foreach (coef[b, t]) coef[b][t] = '0;
      foreach (x_past1[c, b]) begin
        x_past1[c][b] = '0;
        x_past2[c][b] = '0;
        y_past1[c][b] = '0;
        y_past2[c][b] = '0;
      end
      errors = 0;
    endfunction

    // One sample through every band of a channel, then the rounded mean.
    function bank_output_t filter_sample(int ch, logic signed [SAMPLE_W-1:0] x);
      longint acc;
      longint y;
      longint total;
      longint mean;
      bank_output_t r;
      total = 0;
      for (int b = 0; b < BANDS; b++) begin
        // Feed-forward taps are exact; feedback taps are halved with floor.
        acc = longint'(coef[b][C_B0]) * longint'(x) * 2
            + longint'(coef[b][C_B1]) * longint'(x_past1[ch][b]) * 2
            + longint'(coef[b][C_B2]) * longint'(x_past2[ch][b]) * 2
            - ((longint'(coef[b][C_A1]) * longint'(y_past1[ch][b])) >>> 1)
            - ((longint'(coef[b][C_A2]) * longint'(y_past2[ch][b])) >>> 1);
        y = (acc + (longint'(1) << 26)) >>> 27;
        if (y > Y_MAX) y = Y_MAX;
        if (y < Y_MIN) y = Y_MIN;
        x_past2[ch][b] = x_past1[ch][b];
        x_past1[ch][b] = x;
        y_past2[ch][b] = y_past1[ch][b];
        y_past1[ch][b] = y[YOUT_W-1:0];
        total += y;
      end
      // Divide by 2*BANDS, rounding to nearest with ties away from zero.
      if (total >= 0) mean = (total + BANDS) / (2 * BANDS);
      else mean = -((-total + BANDS) / (2 * BANDS));
      if (mean > OUT_MAX) mean = OUT_MAX;
      if (mean < OUT_MIN) mean = OUT_MIN;
      r.sample  = mean[SAMPLE_W-1:0];
      r.channel = ch[0];
      return r;
    endfunction

    function void note_word(logic op, logic ch, logic signed [SAMPLE_W-1:0] x,
                            logic [1:0] bd, logic [2:0] sel,
                            logic signed [COEF_W-1:0] value);
      if (op == OP_COEF) begin
        if (bd < BANDS && sel < TAPS) coef[bd][sel] = value;
      end else if (ch < CHANNELS) begin
        expected_outputs.push_back(filter_sample(int'(ch), x));
      end
    endfunction

    function void check_result(logic signed [SAMPLE_W-1:0] s, logic ch);
      bank_output_t e;
      if (expected_outputs.size() == 0) begin
        $error("unexpected result word: sample_out=%0d channel_out=%0d", s, ch);
        errors++;
        return;
      end
      e = expected_outputs.pop_front();
      if (s !== e.sample) begin
        $error("sample_out: expected %0d, actual %0d", e.sample, s);
        errors++;
      end
      if (ch !== e.channel) begin
        $error("channel_out: expected %0d, actual %0d", e.channel, ch);
        errors++;
      end
    endfunction

    function int pending();
      return expected_outputs.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and the block's ports. Every input has a known value from
  // time zero; afterwards inputs change only by nonblocking assignment at a
  // rising edge, and all sampling happens at the rising edge, so the values
  // seen are the ones that were stable during the preceding cycle.
  // --------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                       item_valid   = 1'b0;
  logic                       item_stall;
  logic                       operation    = OP_SAMPLE;
  logic                       channel      = 1'b0;
  logic signed [SAMPLE_W-1:0] sample_in    = '0;
  logic [1:0]                 band         = '0;
  logic [2:0]                 coeff_select = C_B0;
  logic signed [COEF_W-1:0]   coeff_value  = '0;

  logic                       result_valid;
  logic                       result_stall = 1'b0;
  logic signed [SAMPLE_W-1:0] sample_out;
  logic                       channel_out;

  always #(CLK_PERIOD / 2) clk = ~clk;

  parallel_biquad_formant_bank #(
    .BANDS    (BANDS),
    .CHANNELS (CHANNELS)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .operation    (operation),
    .channel      (channel),
    .sample_in    (sample_in),
    .band         (band),
    .coeff_select (coeff_select),
    .coeff_value  (coeff_value),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .sample_out   (sample_out),
    .channel_out  (channel_out)
  );

  bank_scoreboard sb;

  // Idling controls shared by the sender and the receiver processes.
  bit tx_idling    = 1'b1;
  bit rx_idling    = 1'b1;
  bit hold_request = 1'b0;
  int items_sent   = 0;

  // --------------------------------------------------------------------------
  // Monitor: an input word counts when valid is high and stall low at the
  // edge; the same rule applies to a result word.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst) begin
      if (item_valid && !item_stall) begin
        sb.note_word(operation, channel, sample_in, band, coeff_select, coeff_value);
      end
      if (result_valid && !result_stall) begin
        sb.check_result(sample_out, channel_out);
      end
    end
  end

  // Run limit, far above the slowest legal run.
  int unsigned cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("FAIL parallel_biquad_formant_bank");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Receiver. Stall comes in random bursts while idling is enabled. A hold
  // request from the sender side starts one long hold that this process
  // counts out itself; meanwhile the block finishes its word, takes the next
  // one and then has to stall its input. result_stall gets exactly one
  // assignment per edge.
  // --------------------------------------------------------------------------
  initial begin : receiver
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (stall_left == 0) begin
        if (hold_request) begin
          hold_request = 1'b0;
          stall_left = LONG_HOLD_CYCLES;
        end else if (rx_idling && $urandom_range(0, 5) == 0) begin
          stall_left = $urandom_range(1, 16);
        end
      end
      if (stall_left > 0) begin
        result_stall <= 1'b1;
        stall_left--;
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender tasks. Each is entered right after a rising edge. send_word may
  // open with an idle burst, then offers the word and returns at the edge
  // where it is taken. Valid is never dropped between back-to-back words,
  // so it sees a single assignment in any one time step.
  // --------------------------------------------------------------------------
  task automatic send_word(input logic op, input logic ch,
                           input logic signed [SAMPLE_W-1:0] x,
                           input logic [1:0] bd, input logic [2:0] sel,
                           input logic signed [COEF_W-1:0] value);
    if (tx_idling && $urandom_range(0, 3) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    item_valid   <= 1'b1;
    operation    <= op;
    channel      <= ch;
    sample_in    <= x;
    band         <= bd;
    coeff_select <= sel;
    coeff_value  <= value;
    do @(posedge clk); while (item_stall);
    // Writes to a select code past the last tap are dropped by the block.
    if (op == OP_SAMPLE || sel < TAPS) items_sent++;
  endtask

  // Fields a word does not use carry random bits; the block must ignore them.
  task automatic write_coef(input logic [1:0] bd, input logic [2:0] sel,
                            input logic signed [COEF_W-1:0] value);
    send_word(OP_COEF, 1'($urandom_range(0, 1)), SAMPLE_W'($urandom()), bd, sel, value);
  endtask

  task automatic play_sample(input logic ch, input logic signed [SAMPLE_W-1:0] x);
    send_word(OP_SAMPLE, ch, x, 2'($urandom_range(0, 3)), 3'($urandom_range(0, SEL_LAST)),
              $urandom());
  endtask

  // A random stable section: a2 within the unit interval, a1 inside the
  // stability triangle, feed-forward gains within one half.
  task automatic program_band(input logic [1:0] bd);
    int a1;
    int a2;
    int bound;
    a2 = int'($urandom_range(0, 2 * A2_LIMIT)) - A2_LIMIT;
    bound = COEF_ONE + a2 - STABILITY_MARGIN;
    a1 = int'($urandom_range(0, 2 * bound)) - bound;
    write_coef(bd, C_B0, int'($urandom_range(0, COEF_ONE)) - COEF_ONE / 2);
    write_coef(bd, C_B1, int'($urandom_range(0, COEF_ONE)) - COEF_ONE / 2);
    write_coef(bd, C_B2, int'($urandom_range(0, COEF_ONE)) - COEF_ONE / 2);
    write_coef(bd, C_A1, a1);
    write_coef(bd, C_A2, a2);
  endtask

  // Audio content: extremes, silence, full-scale noise and quiet signals.
  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    logic [31:0] raw;
    raw = $urandom();
    case ($urandom_range(0, 9))
      0: return SAT_POS;
      1: return SAT_NEG;
      2: return '0;
      3, 4, 5: return raw[SAMPLE_W-1:0];
      default: return SAMPLE_W'(int'($urandom_range(0, 2 * SMALL_SAMPLE)) - SMALL_SAMPLE);
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Main sequence.
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int choice;
    int n;
    bit same_channel;
    bit hold_done;
    bit pause_done;
    logic ch;

    sb = new();
    hold_done = 1'b0;
    pause_done = 1'b0;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Directed opening. With every coefficient zero the bank is silent.
    play_sample(1'b0, SAT_POS);
    play_sample(1'b1, SAT_NEG);

    // A unity b0 on one band: odd inputs land exactly on a rounding tie,
    // on both sides of zero.
    write_coef(2'd0, C_B0, COEF_ONE);
    play_sample(1'b0, SAT_POS);
    play_sample(1'b0, SAT_NEG);
    play_sample(1'b1, SAMPLE_W'(-1));

    // Writes to select codes beyond the last tap must change nothing.
    write_coef(2'd0, 3'(SEL_LAST), COEF_MAX);
    write_coef(2'd3, 3'(TAPS), COEF_MIN);
    play_sample(1'b0, SAMPLE_W'(1));

    // Full-scale gain on every band drives the mean into saturation.
    for (int b = 0; b < BANDS; b++) write_coef(2'(b), C_B0, COEF_MAX);
    play_sample(1'b0, SAT_POS);
    play_sample(1'b1, SAT_NEG);

    // Extreme feedback and history taps push the band outputs to their
    // 32-bit limits and keep them there.
    write_coef(2'd1, C_A1, COEF_MIN);
    write_coef(2'd1, C_A2, COEF_MAX);
    write_coef(2'd2, C_B1, COEF_MIN);
    write_coef(2'd2, C_B2, COEF_MAX);
    write_coef(2'd3, C_A2, COEF_MIN);
    play_sample(1'b0, SAT_POS);
    play_sample(1'b0, SAT_POS);
    play_sample(1'b0, '0);
    play_sample(1'b1, SAT_NEG);
    play_sample(1'b1, SAT_NEG);

    // Random part: mostly reprogram a band with a stable section and then
    // stream audio through it, with occasional raw full-range writes,
    // dropped writes and silenced bands mixed in.
    while (items_sent < ITEM_TARGET) begin
      if (items_sent >= ITEM_TARGET - QUIET_ITEMS) begin
        tx_idling = 1'b0;
        rx_idling = 1'b0;
      end else begin
        tx_idling = $urandom_range(0, 2) != 0;
        rx_idling = $urandom_range(0, 2) != 0;
      end

      // Hold the result side for a long stretch while words keep coming.
      if (!hold_done && items_sent >= ITEM_TARGET / 3) begin
        hold_done = 1'b1;
        tx_idling = 1'b0;
        hold_request = 1'b1;
        repeat (8) play_sample(1'($urandom_range(0, CHANNELS - 1)), pick_sample());
      end

      // Let the block run completely dry once before going on.
      if (!pause_done && items_sent >= 2 * ITEM_TARGET / 3) begin
        pause_done = 1'b1;
        item_valid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
      end

      choice = $urandom_range(0, 9);
      if (choice <= 5) begin
        program_band(2'($urandom_range(0, BANDS - 1)));
      end else if (choice == 6) begin
        for (int b = 0; b < BANDS; b++) program_band(2'(b));
      end else if (choice == 7) begin
        n = $urandom_range(0, BANDS - 1);
        for (int t = 0; t < TAPS; t++) write_coef(2'(n), 3'(t), '0);
      end else begin
        repeat ($urandom_range(1, 4)) begin
          write_coef(2'($urandom_range(0, BANDS - 1)), 3'($urandom_range(0, SEL_LAST)),
                     $urandom());
        end
      end

      n = $urandom_range(2, 24);
      same_channel = 1'($urandom_range(0, 1));
      ch = 1'($urandom_range(0, CHANNELS - 1));
      repeat (n) begin
        if (!same_channel) ch = 1'($urandom_range(0, CHANNELS - 1));
        play_sample(ch, pick_sample());
      end
    end

    // Wait for every outstanding result, then watch a while for strays.
    item_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS parallel_biquad_formant_bank");
    end else begin
      $display("FAIL parallel_biquad_formant_bank");
    end
    $finish;
  end

endmodule
